[design/u16u8_pkg.sv]
`default_nettype none
package u16u8_pkg;

	// Result status codes.
	localparam logic [1:0] ST_DATA = 2'd0;
	localparam logic [1:0] ST_OK   = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;
	localparam logic [1:0] ST_LONG = 2'd3;

	// Register indexes on the configuration port.
	localparam logic CFG_LITTLE_ENDIAN = 1'b0;
	localparam logic CFG_MAX_OUT_BYTES = 1'b1;

	// Upper six bits of a code unit that mark the surrogate halves.
	localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
	localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

	// Code points above the basic plane start here.
	localparam logic [20:0] SUPP_BASE = 21'h10000;

	// Upper bounds of the one, two and three byte ranges.
	localparam logic [20:0] CP_LIM_1 = 21'h80;
	localparam logic [20:0] CP_LIM_2 = 21'h800;
	localparam logic [20:0] CP_LIM_3 = 21'h10000;

	// The byte count is eight bits wide, so no string may reach this length.
	localparam int LEN_CAP = 256;

	// Entries in the job queue between the classifier and the emitter.
	localparam int QDEPTH = 2;

	// One classified code unit: up to four data bytes and an optional closing item.
	typedef struct packed {
		logic [3:0][7:0] data_bytes;
		logic [2:0]      n_data;
		logic            has_close;
		logic [1:0]      close_status;
		logic [7:0]      base_len;
	} job_t;

endpackage
`default_nettype wire

[design/u16u8_front.sv]
`default_nettype none
module u16u8_front #(
	parameter int NAME_LIMIT = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              little_endian,
	input  wire logic [15:0]       max_out_bytes,
	input  wire logic              in_fire,
	input  wire logic [15:0]       code_unit,
	input  wire logic              last_unit,
	output logic                   push,
	output u16u8_pkg::job_t        job
);

	localparam logic [8:0] LIM_CAP =
		9'((NAME_LIMIT < u16u8_pkg::LEN_CAP) ? NAME_LIMIT : u16u8_pkg::LEN_CAP);

	logic [9:0]  pend_bits_q;
	logic        pend_valid_q;
	logic [7:0]  bw_q;
	logic        disc_q;

	logic [9:0]  pend_bits_d;
	logic        pend_valid_d;
	logic [7:0]  bw_d;
	logic        disc_d;

	logic [15:0] v;
	logic        is_low;
	logic        is_high;
	logic [20:0] cp;
	logic [2:0]  len;
	logic [8:0]  sum;
	logic [8:0]  limit;
	logic [3:0][7:0] enc;

	always_comb begin
		v       = little_endian ? {code_unit[7:0], code_unit[15:8]} : code_unit;
		is_low  = (v[15:10] == u16u8_pkg::LOW_SURR_TAG);
		is_high = (v[15:10] == u16u8_pkg::HIGH_SURR_TAG);
		cp      = pend_valid_q ? ({1'b0, pend_bits_q, v[9:0]} + u16u8_pkg::SUPP_BASE)
			: {5'd0, v};

		if (cp < u16u8_pkg::CP_LIM_1) begin
			len = 3'd1;
		end else if (cp < u16u8_pkg::CP_LIM_2) begin
			len = 3'd2;
		end else if (cp < u16u8_pkg::CP_LIM_3) begin
			len = 3'd3;
		end else begin
			len = 3'd4;
		end

		sum   = {1'b0, bw_q} + {6'd0, len};
		limit = (max_out_bytes < {7'd0, LIM_CAP}) ? max_out_bytes[8:0] : LIM_CAP;

		enc = '0;
		case (len)
			3'd1: begin
				enc[0] = cp[7:0];
			end
			3'd2: begin
				enc[0] = {3'b110, cp[10:6]};
				enc[1] = {2'b10, cp[5:0]};
			end
			3'd3: begin
				enc[0] = {4'b1110, cp[15:12]};
				enc[1] = {2'b10, cp[11:6]};
				enc[2] = {2'b10, cp[5:0]};
			end
			default: begin
				enc[0] = {5'b11110, cp[20:18]};
				enc[1] = {2'b10, cp[17:12]};
				enc[2] = {2'b10, cp[11:6]};
				enc[3] = {2'b10, cp[5:0]};
			end
		endcase

		push         = 1'b0;
		job          = '0;
		job.base_len = bw_q;
		pend_bits_d  = pend_bits_q;
		pend_valid_d = pend_valid_q;
		bw_d         = bw_q;
		disc_d       = disc_q;

		if (in_fire) begin
			if (disc_q) begin
				if (last_unit) begin
					disc_d = 1'b0;
				end
			end else if ((max_out_bytes == 16'd0) || (pend_valid_q && !is_low) ||
					(!pend_valid_q && is_low) ||
					(!pend_valid_q && is_high && last_unit)) begin
				push             = 1'b1;
				job.has_close    = 1'b1;
				job.close_status = u16u8_pkg::ST_BAD;
				pend_bits_d      = '0;
				pend_valid_d     = 1'b0;
				bw_d             = '0;
				disc_d           = !last_unit;
			end else if (!pend_valid_q && is_high) begin
				pend_bits_d  = v[9:0];
				pend_valid_d = 1'b1;
			end else if (sum >= limit) begin
				push             = 1'b1;
				job.has_close    = 1'b1;
				job.close_status = u16u8_pkg::ST_LONG;
				pend_bits_d      = '0;
				pend_valid_d     = 1'b0;
				bw_d             = '0;
				disc_d           = !last_unit;
			end else begin
				push             = 1'b1;
				job.data_bytes   = enc;
				job.n_data       = len;
				job.has_close    = last_unit;
				job.close_status = u16u8_pkg::ST_OK;
				pend_bits_d      = '0;
				pend_valid_d     = 1'b0;
				bw_d             = last_unit ? 8'd0 : sum[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q  <= '0;
			pend_valid_q <= 1'b0;
			bw_q         <= '0;
			disc_q       <= 1'b0;
		end else begin
			pend_bits_q  <= pend_bits_d;
			pend_valid_q <= pend_valid_d;
			bw_q         <= bw_d;
			disc_q       <= disc_d;
		end
	end

endmodule
`default_nettype wire

[design/u16u8_queue.sv]
`default_nettype none
module u16u8_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire u16u8_pkg::job_t  push_job,
	output logic                  full,
	input  wire logic             pop,
	output logic                  head_valid,
	output u16u8_pkg::job_t       head_job
);

	localparam int PW = (u16u8_pkg::QDEPTH > 1) ? $clog2(u16u8_pkg::QDEPTH) : 1;
	localparam int CW = $clog2(u16u8_pkg::QDEPTH + 1);

	u16u8_pkg::job_t entry_q [u16u8_pkg::QDEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full       = (count_q == CW'(u16u8_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(u16u8_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(u16u8_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[design/u16u8_back.sv]
`default_nettype none
module u16u8_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             head_valid,
	input  wire u16u8_pkg::job_t  head_job,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [7:0]            out_byte,
	output logic [1:0]            status,
	output logic [7:0]            out_length,
	output logic                  last_of_run
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic [1:0] status_q;
	logic [7:0] len_q;
	logic       last_q;

	logic       load;
	logic [2:0] total;
	logic       is_final;
	logic       is_data;
	logic [7:0] nxt_byte;
	logic [1:0] nxt_status;
	logic [7:0] nxt_len;

	always_comb begin
		total    = head_job.n_data + {2'd0, head_job.has_close};
		is_final = ((idx_q + 3'd1) == total);
		is_data  = (idx_q < head_job.n_data);
		load     = head_valid && (!out_valid_q || out_ready);
		pop      = load && is_final;
		if (is_data) begin
			nxt_byte   = head_job.data_bytes[idx_q[1:0]];
			nxt_status = u16u8_pkg::ST_DATA;
			nxt_len    = head_job.base_len + {5'd0, idx_q} + 8'd1;
		end else begin
			nxt_byte   = 8'd0;
			nxt_status = head_job.close_status;
			nxt_len    = head_job.base_len + {5'd0, head_job.n_data};
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= nxt_byte;
			status_q <= nxt_status;
			len_q    <= nxt_len;
			last_q   <= is_final;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= is_final ? 3'd0 : idx_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = byte_q;
	assign status      = status_q;
	assign out_length  = len_q;
	assign last_of_run = last_q;

endmodule
`default_nettype wire

[design/utf16_to_utf8_stream_converter.sv]
`default_nettype none
// UTF-16 to UTF-8 stream converter. Each input transfer carries one 16-bit code
// unit (first memory byte in bits 15:8) and a flag marking the last unit of a
// string; little_endian selects whether the two bytes are swapped before use.
// Surrogate pairs are joined into one code point, and every code point leaves as
// 1 to 4 UTF-8 data bytes, one output transfer each, with out_length counting the
// bytes of the string so far. The last unit of a string adds a closing transfer
// with a NUL byte, status 1 and the final length. A lone low surrogate, a high
// surrogate not followed by a low one, a high surrogate at the end of a string,
// or a zero max_out_bytes closes the string with status 2; output that would
// reach min(max_out_bytes, NAME_LIMIT, 256) bytes closes it with status 3. After
// either, the remaining units of that string produce nothing. last_of_run marks
// the final output transfer caused by an input unit; a held high surrogate and
// swallowed units cause none. Timing: the classifier takes one code unit per
// cycle while its two-entry job queue has room, and the output register sends
// one result per cycle while out_ready is high, so the output port sets the
// sustained rate. The first result of a unit passes through the job queue and
// then the output register before it is presented. Write the configuration
// registers only while the converter is idle.
module utf16_to_utf8_stream_converter #(
	parameter int NAME_LIMIT = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] code_unit,
	input  wire logic        last_unit,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic [1:0]       status,
	output logic [7:0]       out_length,
	output logic             last_of_run
);

	// Configuration registers, reset to little-endian and a 256-byte buffer.
	logic        little_endian_q;
	logic [15:0] max_out_bytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			little_endian_q <= 1'b1;
			max_out_bytes_q <= 16'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				u16u8_pkg::CFG_LITTLE_ENDIAN: little_endian_q <= cfg_wdata[0];
				default:                      max_out_bytes_q <= cfg_wdata;
			endcase
		end
	end

	logic            q_full;
	logic            in_fire;
	logic            push;
	u16u8_pkg::job_t push_job;
	logic            pop;
	logic            head_valid;
	u16u8_pkg::job_t head_job;

	// The classifier commits its string state on every accepted unit, so it
	// only accepts when the queue can take whatever job the unit produces.
	assign in_ready = !q_full;
	assign in_fire  = in_valid && in_ready;

	u16u8_front #(
		.NAME_LIMIT(NAME_LIMIT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.little_endian(little_endian_q),
		.max_out_bytes(max_out_bytes_q),
		.in_fire      (in_fire),
		.code_unit    (code_unit),
		.last_unit    (last_unit),
		.push         (push),
		.job          (push_job)
	);

	u16u8_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_job  (head_job)
	);

	// The emitter walks each job into the output register one result per cycle while out_ready allows.
	u16u8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.status     (status),
		.out_length (out_length),
		.last_of_run(last_of_run)
	);

`ifndef ASSERT_OFF
	// A closing result always ends the run of its input unit.
	a_close_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != u16u8_pkg::ST_DATA) |-> last_of_run)
		else $error("closing result without last_of_run");

	// A data byte always counts at least itself.
	a_data_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == u16u8_pkg::ST_DATA) |-> (out_length != 8'd0))
		else $error("data byte with zero length");

	// An empty queue never blocks the input.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> in_ready)
		else $error("input stalled with an empty queue");

	// Only a job that is being emitted may be popped.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid && (!out_valid || out_ready))
		else $error("queue popped without a result load");
`endif

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps

// Self-checking bench for the UTF-16 to UTF-8 stream converter.
//
// The main initial block runs a list of named tests. Each test sends code units
// through one shared send task. That task also runs the transcoding predictor
// at the moment a unit is accepted. The predictor keeps its own copy of the
// register settings and of the string state (held high surrogate, byte count,
// swallow flag). It appends the UTF-8 bytes and closing items that the unit
// should cause to a queue of expected results. A separate checker process pops
// that queue on every output transfer and compares all four fields.
//
// Registers are only written while the converter is idle. The bench first stops
// sending and waits until every expected result has arrived. It then waits out
// DRAIN_CYCLES more, because a held high surrogate or a swallowed unit causes no
// result, yet may still be inside the converter.
module tb_top;

	localparam int NAME_LIMIT   = 256;
	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 7;
	// The job queue is two entries deep and sits behind an output register, so this
	// wait is ample for anything still in flight to come out.
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 250000;
	localparam int RANDOM_UNITS = 70;

	// One expected output transfer.
	typedef struct packed {
		logic [7:0] data;
		logic [1:0] st;
		logic [7:0] len;
		logic       eor;
	} utf8_item_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_we      = 1'b0;
	logic        cfg_index   = u16u8_pkg::CFG_LITTLE_ENDIAN;
	logic [15:0] cfg_wdata   = '0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [15:0] code_unit   = '0;
	logic        last_unit   = 1'b0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [7:0]  out_byte;
	logic [1:0]  status;
	logic [7:0]  out_length;
	logic        last_of_run;

	// The predictor's copy of the registers and of the string state.
	logic        cfg_swap   = 1'b1;
	logic [15:0] cfg_max    = 16'd256;
	logic [9:0]  hold_bits  = '0;
	logic        hold_valid = 1'b0;
	logic [7:0]  str_len    = '0;
	logic        skip_rest  = 1'b0;

	// Results of the unit being predicted, before they go to the queue.
	utf8_item_t run_buf [0:4];
	int         run_len;

	utf8_item_t utf8_expect_q [$];

	int failures    = 0;
	int units_sent  = 0;
	int bytes_seen  = 0;
	int closes_ok   = 0;
	int closes_bad  = 0;
	int closes_long = 0;
	int cfg_writes  = 0;
	int cycle_count = 0;
	int burst_left  = 0;
	int stall_mode  = 0;
	int stall_left  = 0;

	utf16_to_utf8_stream_converter #(
		.NAME_LIMIT(NAME_LIMIT)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.code_unit  (code_unit),
		.last_unit  (last_unit),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.status     (status),
		.out_length (out_length),
		.last_of_run(last_of_run)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// A run that hangs ends here with a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// The receiver switches its stall behavior at random intervals: always
	// ready, mostly ready, mostly stalled, or a fixed two-in-three rhythm.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 80);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= ($urandom_range(0, 2) == 0);
			default: out_ready <= ((stall_left % 3) != 0);
		endcase
	end

	// Reports one field that differs from its expectation.
	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			failures++;
		end
	endtask

	// Output checker. Values are read right after the edge, so they are the ones
	// that the transfer at that edge carried.
	always @(posedge clk) begin
		utf8_item_t exp_item;
		if (arst_n && out_valid && out_ready) begin
			if (utf8_expect_q.size() == 0) begin
				$error("unexpected transfer: out_byte 0x%0h status %0d out_length %0d",
					out_byte, status, out_length);
				failures++;
			end else begin
				exp_item = utf8_expect_q.pop_front();
				check_field("out_byte", int'(exp_item.data), int'(out_byte));
				check_field("status", int'(exp_item.st), int'(status));
				check_field("out_length", int'(exp_item.len), int'(out_length));
				check_field("last_of_run", int'(exp_item.eor), int'(last_of_run));
				case (exp_item.st)
					u16u8_pkg::ST_DATA: bytes_seen++;
					u16u8_pkg::ST_OK:   closes_ok++;
					u16u8_pkg::ST_BAD:  closes_bad++;
					default:            closes_long++;
				endcase
			end
		end
	end

	task automatic add_result(input logic [7:0] data, input logic [1:0] st,
			input logic [7:0] len);
		run_buf[run_len] = '{data: data, st: st, len: len, eor: 1'b0};
		run_len++;
	endtask

	// Ends the current string with a closing item. If the unit was not the last
	// of its string, the rest of the string gets swallowed.
	task automatic close_string(input logic [1:0] st, input logic fin);
		add_result(8'h00, st, str_len);
		hold_bits  = '0;
		hold_valid = 1'b0;
		str_len    = '0;
		skip_rest  = !fin;
	endtask

	// Predicts the UTF-8 output of one accepted code unit and queues it.
	task automatic predict_utf8(input logic [15:0] stored, input logic fin);
		logic [15:0]      v;
		logic [20:0]      cp;
		logic             have_cp;
		logic [3:0][7:0]  enc;
		int               nbytes;
		int               cap;
		utf8_item_t       item;
		run_len = 0;
		have_cp = 1'b0;
		cp      = '0;
		if (skip_rest) begin
			if (fin)
				skip_rest = 1'b0;
		end else if (cfg_max == 16'd0) begin
			close_string(u16u8_pkg::ST_BAD, fin);
		end else begin
			v = cfg_swap ? {stored[7:0], stored[15:8]} : stored;
			if (hold_valid) begin
				if (v[15:10] != u16u8_pkg::LOW_SURR_TAG) begin
					close_string(u16u8_pkg::ST_BAD, fin);
				end else begin
					cp         = {1'b0, hold_bits, v[9:0]} + u16u8_pkg::SUPP_BASE;
					hold_bits  = '0;
					hold_valid = 1'b0;
					have_cp    = 1'b1;
				end
			end else if (v[15:10] == u16u8_pkg::LOW_SURR_TAG) begin
				close_string(u16u8_pkg::ST_BAD, fin);
			end else if (v[15:10] == u16u8_pkg::HIGH_SURR_TAG) begin
				if (fin) begin
					close_string(u16u8_pkg::ST_BAD, fin);
				end else begin
					hold_bits  = v[9:0];
					hold_valid = 1'b1;
				end
			end else begin
				cp      = {5'd0, v};
				have_cp = 1'b1;
			end
		end

		if (have_cp) begin
			if (cp < u16u8_pkg::CP_LIM_1)
				nbytes = 1;
			else if (cp < u16u8_pkg::CP_LIM_2)
				nbytes = 2;
			else if (cp < u16u8_pkg::CP_LIM_3)
				nbytes = 3;
			else
				nbytes = 4;
			// The smallest of buffer size, name limit and what the count can hold.
			cap = int'(cfg_max);
			if (cap > NAME_LIMIT)
				cap = NAME_LIMIT;
			if (cap > u16u8_pkg::LEN_CAP)
				cap = u16u8_pkg::LEN_CAP;
			if (int'(str_len) + nbytes >= cap) begin
				close_string(u16u8_pkg::ST_LONG, fin);
			end else begin
				case (nbytes)
					1: enc[0] = cp[7:0];
					2: begin
						enc[0] = {3'b110, cp[10:6]};
						enc[1] = {2'b10, cp[5:0]};
					end
					3: begin
						enc[0] = {4'b1110, cp[15:12]};
						enc[1] = {2'b10, cp[11:6]};
						enc[2] = {2'b10, cp[5:0]};
					end
					default: begin
						enc[0] = {5'b11110, cp[20:18]};
						enc[1] = {2'b10, cp[17:12]};
						enc[2] = {2'b10, cp[11:6]};
						enc[3] = {2'b10, cp[5:0]};
					end
				endcase
				for (int i = 0; i < nbytes; i++) begin
					str_len = str_len + 8'd1;
					add_result(enc[i], u16u8_pkg::ST_DATA, str_len);
				end
				if (fin)
					close_string(u16u8_pkg::ST_OK, 1'b1);
			end
		end

		for (int i = 0; i < run_len; i++) begin
			item     = run_buf[i];
			item.eor = (i == run_len - 1);
			utf8_expect_q.push_back(item);
		end
	endtask

	// Sends one code unit exactly as it should appear on the port. The sender
	// works in bursts; between bursts it drops valid for a random gap, and now
	// and then a long burst runs with no gap at all.
	task automatic send_unit(input logic [15:0] stored, input logic fin);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid  <= 1'b1;
		code_unit <= stored;
		last_unit <= fin;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_utf8(stored, fin);
		burst_left--;
		units_sent++;
	endtask

	// Sends a logical UTF-16 value, put into the configured memory byte order.
	task automatic send_value(input logic [15:0] v, input logic fin);
		send_unit(cfg_swap ? {v[7:0], v[15:8]} : v, fin);
	endtask

	// Sends a code point as one unit, or as a surrogate pair above the basic plane.
	task automatic send_code_point(input logic [20:0] cp, input logic fin);
		logic [19:0] off;
		if (cp >= u16u8_pkg::SUPP_BASE) begin
			off = 20'(cp - u16u8_pkg::SUPP_BASE);
			send_value({u16u8_pkg::HIGH_SURR_TAG, off[19:10]}, 1'b0);
			send_value({u16u8_pkg::LOW_SURR_TAG, off[9:0]}, fin);
		end else begin
			send_value(cp[15:0], fin);
		end
	endtask

	function automatic logic [20:0] random_code_point();
		logic [20:0] cp;
		case ($urandom_range(0, 3))
			0: cp = 21'($urandom_range(0, 'h7F));
			1: cp = 21'($urandom_range('h80, 'h7FF));
			2: begin
				// Anything from the three byte range except the surrogate block.
				cp = 21'($urandom_range('h800, 'hF7FF));
				if (cp >= 21'hD800)
					cp = cp + 21'h800;
			end
			default: cp = 21'($urandom_range('h10000, 'h10FFFF));
		endcase
		return cp;
	endfunction

	// Stops sending and waits until the converter has gone quiet. This is also
	// the point where the sender holds off until every expected result is in.
	task automatic wait_idle();
		in_valid  <= 1'b0;
		burst_left = 0;
		while (utf8_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		if (idx == u16u8_pkg::CFG_LITTLE_ENDIAN)
			cfg_swap = value[0];
		else
			cfg_max = value;
		cfg_writes++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic le, input logic [15:0] max_bytes);
		wait_idle();
		write_reg(u16u8_pkg::CFG_LITTLE_ENDIAN, {15'd0, le});
		write_reg(u16u8_pkg::CFG_MAX_OUT_BYTES, max_bytes);
	endtask

	// Reset settings: little-endian units, a 256 byte buffer. The boundaries of
	// each UTF-8 length, a NUL unit, and both ends of the supplementary planes.
	task automatic test_encoding_lengths();
		send_code_point(21'h41, 1'b0);
		send_code_point(21'h7F, 1'b0);
		send_code_point(21'h80, 1'b0);
		send_code_point(21'h7FF, 1'b0);
		send_code_point(21'h800, 1'b0);
		send_code_point(21'hFFFF, 1'b1);
		send_code_point(21'h0, 1'b1);
		send_code_point(21'h10000, 1'b1);
		send_code_point(21'h10FFFF, 1'b1);
		wait_idle();
	endtask

	// Every way a surrogate can be out of place, with and without the rest of
	// the string being swallowed afterwards.
	task automatic test_surrogate_errors();
		// A lone low surrogate, then two units that get swallowed.
		send_value(16'hDC00, 1'b0);
		send_value(16'h0041, 1'b0);
		send_value(16'h0042, 1'b1);
		// A high surrogate followed by a plain character.
		send_value(16'hD83D, 1'b0);
		send_value(16'h0041, 1'b0);
		send_value(16'h0043, 1'b1);
		// A high surrogate on the last unit of a string.
		send_value(16'hD800, 1'b1);
		// A lone low surrogate that is also the last unit.
		send_value(16'hDFFF, 1'b1);
		// One byte of data, then a high surrogate followed by another high one.
		send_value(16'h0061, 1'b0);
		send_value(16'hDBFF, 1'b0);
		send_value(16'hD800, 1'b1);
		wait_idle();
	endtask

	task automatic test_big_endian();
		configure(1'b0, 16'd256);
		send_code_point(21'h1234, 1'b0);
		send_code_point(21'h1F600, 1'b0);
		send_code_point(21'hE9, 1'b1);
		wait_idle();
	endtask

	// A zero buffer makes every string bad; a one byte buffer cannot hold any
	// character; a four byte buffer overflows on the fourth byte.
	task automatic test_small_buffers();
		configure(1'b1, 16'd0);
		send_value(16'h0041, 1'b0);
		send_value(16'h0042, 1'b1);
		send_value(16'h0043, 1'b1);
		configure(1'b0, 16'd1);
		send_value(16'h0041, 1'b1);
		configure(1'b1, 16'd4);
		send_value(16'h0041, 1'b0);
		send_value(16'h0042, 1'b0);
		send_value(16'h0043, 1'b0);
		send_value(16'h20AC, 1'b1);
		wait_idle();
	endtask

	// With the largest buffer setting, the eight bit byte count caps a string at
	// 255 bytes. Three and four byte characters run it into that cap.
	task automatic test_length_cap();
		int n;
		configure(1'($urandom_range(0, 1)), 16'hFFFF);
		n = 0;
		while (!skip_rest && n < 140) begin
			if ($urandom_range(0, 3) == 0)
				send_code_point(21'($urandom_range('h10000, 'h10FFFF)), 1'b0);
			else
				send_code_point(21'($urandom_range('h800, 'hD7FF)), 1'b0);
			n++;
		end
		send_value(16'($urandom_range(0, 'hFFFF)), 1'b1);
		wait_idle();
	endtask

	// One random string: mostly well formed, some raw noise, some broken by a
	// misplaced surrogate in the middle or at the end.
	task automatic send_random_string();
		int kind;
		int nchar;
		int brk;
		kind  = $urandom_range(0, 9);
		nchar = $urandom_range(1, 6);
		if (kind <= 6) begin
			for (int i = 0; i < nchar; i++)
				send_code_point(random_code_point(), i == nchar - 1);
		end else if (kind == 7) begin
			for (int i = 0; i < nchar; i++)
				send_unit(16'($urandom_range(0, 'hFFFF)), i == nchar - 1);
		end else begin
			for (int i = 0; i < nchar; i++)
				send_code_point(random_code_point(), 1'b0);
			brk = $urandom_range(0, 2);
			if (brk == 0) begin
				send_value({u16u8_pkg::LOW_SURR_TAG, 10'($urandom_range(0, 'h3FF))},
					1'b0);
			end else if (brk == 1) begin
				send_value({u16u8_pkg::HIGH_SURR_TAG, 10'($urandom_range(0, 'h3FF))},
					1'b0);
				send_code_point(random_code_point(), 1'b0);
			end else begin
				send_value({u16u8_pkg::HIGH_SURR_TAG, 10'($urandom_range(0, 'h3FF))},
					1'b1);
			end
			if (brk != 2) begin
				for (int i = 0; i < nchar; i++)
					send_code_point(random_code_point(), i == nchar - 1);
			end
		end
	endtask

	// Random strings over a series of random settings, small buffers favored so
	// that overflow shows up often.
	task automatic test_random_strings();
		int          target;
		int          phase_end;
		logic [15:0] max_bytes;
		target = units_sent + RANDOM_UNITS;
		while (units_sent < target) begin
			case ($urandom_range(0, 7))
				0: max_bytes = 16'd0;
				1: max_bytes = 16'($urandom_range(1, 4));
				2, 3: max_bytes = 16'($urandom_range(5, 24));
				4: max_bytes = 16'($urandom_range(25, 255));
				5: max_bytes = 16'd256;
				6: max_bytes = 16'hFFFF;
				default: max_bytes = 16'($urandom_range(257, 'hFFFF));
			endcase
			configure(1'($urandom_range(0, 1)), max_bytes);
			phase_end = units_sent + $urandom_range(10, 20);
			while (units_sent < phase_end)
				send_random_string();
		end
		wait_idle();
	endtask

	initial begin
		int waited;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_encoding_lengths();
		test_surrogate_errors();
		test_big_endian();
		test_small_buffers();
		test_length_cap();
		test_random_strings();

		// Settle once more, with a bound, and flag anything still owed.
		in_valid <= 1'b0;
		waited = 0;
		while (utf8_expect_q.size() != 0 && waited < 10 * DRAIN_CYCLES) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (utf8_expect_q.size() != 0) begin
			$error("%0d expected results never arrived", utf8_expect_q.size());
			failures++;
		end

		$display("Run covered %0d code units, %0d UTF-8 data bytes and %0d string ends",
			units_sent, bytes_seen, closes_ok + closes_bad + closes_long);
		$display("(%0d ok, %0d bad value, %0d too long) over %0d register writes.",
			closes_ok, closes_bad, closes_long, cfg_writes);
		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
